[rtl/pct_pkg.sv]
package pct_pkg;

  localparam int NumButtons = 5;
  localparam int CoordBits  = 12;
  localparam int TimeBits   = 32;
  localparam int PosBits    = CoordBits + 1;
  localparam int DeltaBits  = CoordBits + 2;
  localparam int SqBits     = 2 * DeltaBits;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CoordBits-1:0] MaxXReset    = CoordBits'(720);
  localparam logic [CoordBits-1:0] MaxYReset    = CoordBits'(576);
  localparam logic [15:0]          DcWinReset   = 16'd500;
  localparam logic [7:0]           MinMoveReset = 8'd5;
  localparam logic [15:0]          TimeoutReset = 16'd5000;

  localparam logic [2:0] BtnWheelUp   = 3'd5;
  localparam logic [2:0] BtnWheelDown = 3'd6;

  localparam logic [1:0] WheelNone = 2'b00;
  localparam logic [1:0] WheelUp   = 2'b01;
  localparam logic [1:0] WheelDown = 2'b11;

  typedef enum logic [1:0] {
    CmdMotion = 2'd0,
    CmdDown   = 2'd1,
    CmdUp     = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegMaxX     = 3'd0,
    RegMaxY     = 3'd1,
    RegDcWindow = 3'd2,
    RegMinMove  = 3'd3,
    RegTimeout  = 3'd4,
    RegEnable   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] max_x;
    logic [CoordBits-1:0] max_y;
    logic [15:0]          dc_window;
    logic [7:0]           min_move;
    logic [15:0]          timeout;
    logic                 enabled;
  } cfg_t;

  // Pulses from a write to max_x or max_y; the core moves the cursor to center.
  typedef struct packed {
    logic                 recenter_x;
    logic                 recenter_y;
    logic [CoordBits-1:0] center;
  } cfg_upd_t;

  typedef struct packed {
    logic [1:0]                  cmd;
    logic signed [PosBits-1:0]   pos_x;
    logic signed [PosBits-1:0]   pos_y;
    logic [2:0]                  button_code;
    logic [TimeBits-1:0]         timestamp;
  } in_item_t;

  typedef struct packed {
    logic [CoordBits-1:0]        cur_x;
    logic [CoordBits-1:0]        cur_y;
    logic signed [DeltaBits-1:0] delta_x;
    logic signed [DeltaBits-1:0] delta_y;
    logic signed [1:0]           wheel;
    logic [4:0]                  held_mask;
    logic [4:0]                  click_mask;
    logic [4:0]                  double_click_mask;
    logic [4:0]                  hold_mask;
    logic                        is_active;
  } out_item_t;

endpackage

[rtl/pointer_click_tracker.sv]
// Channel   Direction  Group      Content
// events    in         s_axis_*   tuser: cmd; tdata: pos_x, pos_y, button_code, timestamp
// results   out        m_axis_*   tdata: position, deltas, wheel, button masks, is_active
// config    in         cfg_*      write enable, register index, write data
//
// One event is taken per cycle unless a stalled result blocks it; it passes through
// the input register, and the cursor, button and activity state are updated in the
// cycle it moves into the output register.
// Reset restores the default configuration and the centered cursor.
// A stalled result holds the output register; the input register still takes
// one more request, and further requests wait until the result is taken.
module pointer_click_tracker import pct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x[12:0], pos_y[25:13], button_code[28:26], timestamp[60:29], zero[63:61]
  input  logic [63:0]            s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cur_x[11:0], cur_y[23:12], delta_x[37:24], delta_y[51:38], wheel[53:52],
  // held_mask[58:54], click_mask[63:59], double_click_mask[68:64],
  // hold_mask[73:69], is_active[74], zero[79:75]
  output logic [79:0]            m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  cfg_upd_t  upd;
  in_item_t  in_q;
  out_item_t res, out_q;
  logic      in_valid_q, out_valid_q, advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.cmd         <= s_axis_tuser;
      in_q.pos_x       <= s_axis_tdata[12:0];
      in_q.pos_y       <= s_axis_tdata[25:13];
      in_q.button_code <= s_axis_tdata[28:26];
      in_q.timestamp   <= s_axis_tdata[60:29];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  pct_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg),
    .upd_o   (upd)
  );

  pct_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .upd_i  (upd),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q.is_active, out_q.hold_mask, out_q.double_click_mask,
                          out_q.click_mask, out_q.held_mask, out_q.wheel, out_q.delta_y,
                          out_q.delta_x, out_q.cur_y, out_q.cur_x};

`ifndef SYNTH
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request lost");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> in_valid_q)
    else $error("pending request dropped during stall");
`endif

endmodule

[rtl/pct_cfg.sv]
module pct_cfg import pct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [CfgIdxBits-1:0]  idx_i,
  input  logic [CfgDataBits-1:0] wdata_i,
  output cfg_t                   cfg_o,
  output cfg_upd_t               upd_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    upd_o = '0;
    // Half of the written limit; only the register's own bits take part.
    upd_o.center = {1'b0, wdata_i[CoordBits-1:1]};
    if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        RegMaxX: begin
          cfg_d.max_x = wdata_i[CoordBits-1:0];
          upd_o.recenter_x = 1'b1;
        end
        RegMaxY: begin
          cfg_d.max_y = wdata_i[CoordBits-1:0];
          upd_o.recenter_y = 1'b1;
        end
        RegDcWindow: cfg_d.dc_window = wdata_i[15:0];
        RegMinMove:  cfg_d.min_move  = wdata_i[7:0];
        RegTimeout:  cfg_d.timeout   = wdata_i[15:0];
        RegEnable:   cfg_d.enabled   = wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_x     <= MaxXReset;
      cfg_q.max_y     <= MaxYReset;
      cfg_q.dc_window <= DcWinReset;
      cfg_q.min_move  <= MinMoveReset;
      cfg_q.timeout   <= TimeoutReset;
      cfg_q.enabled   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/pct_core.sv]
module pct_core import pct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  input  cfg_upd_t  upd_i,
  output out_item_t res_o
);

  logic [CoordBits-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [1:0]            wheel_q, wheel_d;
  logic [NumButtons-1:0] held_q, held_d;
  logic [TimeBits-1:0]   rel_time_q [NumButtons];
  logic [TimeBits-1:0]   last_act_q, last_act_d;
  logic                  active_q, active_d;

  logic signed [DeltaBits-1:0] dx, dy;
  logic signed [SqBits-1:0]    sq_x, sq_y;
  logic [SqBits-1:0]           sq_sum;
  logic [15:0]                 thr;
  logic [NumButtons-1:0]       clicks, dbl, holds, in_window;
  logic [TimeBits-1:0]         idle_gap;
  logic                        hit, still_on;

  function automatic logic [CoordBits-1:0] clamp(logic signed [PosBits-1:0] v,
                                                 logic [CoordBits-1:0] hi);
    logic [CoordBits-1:0] r;
    if (v[PosBits-1]) begin
      r = '0;
    end else if (v[CoordBits-1:0] > hi) begin
      r = hi;
    end else begin
      r = v[CoordBits-1:0];
    end
    return r;
  endfunction

  always_comb begin
    dx = DeltaBits'(item_i.pos_x) - $signed({2'b00, pos_x_q});
    dy = DeltaBits'(item_i.pos_y) - $signed({2'b00, pos_y_q});
    pos_x_d = clamp(item_i.pos_x, cfg_i.max_x);
    pos_y_d = clamp(item_i.pos_y, cfg_i.max_y);

    held_d  = held_q;
    wheel_d = wheel_q;
    case (cmd_e'(item_i.cmd))
      CmdDown: begin
        if (int'(item_i.button_code) < NumButtons) begin
          held_d[item_i.button_code] = 1'b1;
        end else if (item_i.button_code == BtnWheelUp) begin
          wheel_d = WheelUp;
        end else if (item_i.button_code == BtnWheelDown) begin
          wheel_d = WheelDown;
        end
      end
      CmdUp: begin
        if (int'(item_i.button_code) < NumButtons) begin
          held_d[item_i.button_code] = 1'b0;
        end else if (item_i.button_code == BtnWheelUp ||
                     item_i.button_code == BtnWheelDown) begin
          wheel_d = WheelNone;
        end
      end
      default: ;
    endcase

    sq_x   = dx * dx;
    sq_y   = dy * dy;
    sq_sum = SqBits'(sq_x[SqBits-2:0]) + SqBits'(sq_y[SqBits-2:0]);
    thr    = cfg_i.min_move * cfg_i.min_move;

    for (int i = 0; i < NumButtons; i++) begin
      in_window[i] = (item_i.timestamp - rel_time_q[i]) < TimeBits'(cfg_i.dc_window);
    end
    clicks = held_q & ~held_d;
    dbl    = held_d & ~held_q & in_window;
    holds  = held_d & held_q;

    // Any activity this event leaves a gap of zero, so the timeout cannot fire.
    hit        = (sq_sum >= SqBits'(thr)) || (wheel_d != WheelNone) || (|held_d);
    idle_gap   = item_i.timestamp - last_act_q;
    still_on   = active_q && (idle_gap <= TimeBits'(cfg_i.timeout));
    active_d   = hit || still_on;
    last_act_d = hit ? item_i.timestamp : last_act_q;

    res_o.cur_x             = pos_x_d;
    res_o.cur_y             = pos_y_d;
    res_o.delta_x           = dx;
    res_o.delta_y           = dy;
    res_o.wheel             = wheel_d;
    res_o.held_mask         = 5'(held_d);
    res_o.click_mask        = 5'(clicks);
    res_o.double_click_mask = 5'(dbl);
    res_o.hold_mask         = 5'(holds);
    res_o.is_active         = active_d && cfg_i.enabled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= MaxXReset >> 1;
      pos_y_q    <= MaxYReset >> 1;
      wheel_q    <= WheelNone;
      held_q     <= '0;
      last_act_q <= '0;
      active_q   <= 1'b1;
      for (int i = 0; i < NumButtons; i++) begin
        rel_time_q[i] <= '0;
      end
    end else begin
      if (step_i) begin
        pos_x_q    <= pos_x_d;
        pos_y_q    <= pos_y_d;
        wheel_q    <= wheel_d;
        held_q     <= held_d;
        last_act_q <= last_act_d;
        active_q   <= active_d;
        for (int i = 0; i < NumButtons; i++) begin
          if (clicks[i]) begin
            rel_time_q[i] <= item_i.timestamp;
          end
        end
      end
      if (upd_i.recenter_x) begin
        pos_x_q <= upd_i.center;
      end
      if (upd_i.recenter_y) begin
        pos_y_q <= upd_i.center;
      end
    end
  end

`ifndef SYNTH
  a_one_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> $onehot0(held_d ^ held_q))
    else $error("more than one button changed in one event");

  a_click_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && clicks != '0) |=> ((held_q & $past(clicks)) == '0))
    else $error("released button still held");

  a_hit_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && hit) |=> (active_q && last_act_q == $past(item_i.timestamp)))
    else $error("activity not recorded");
`endif

endmodule

[tb/pointer_click_tracker_tb.sv]
`timescale 1ns / 100ps

module pointer_click_tracker_tb;
  import pct_pkg::*;

  localparam logic [1:0]            CmdSpare    = 2'd3;
  localparam logic [2:0]            BtnNone     = 3'd7;
  localparam logic [CfgIdxBits-1:0] RegUnused   = 3'd7;
  localparam int                    DrainCycles = 4;
  localparam int                    CycleLimit  = 400000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [63:0]            s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [79:0]            m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;

  // Tracker configuration and state as the block should hold them.
  logic [CoordBits-1:0]  cfg_max_x, cfg_max_y;
  logic [15:0]           cfg_dc_window, cfg_timeout;
  logic [7:0]            cfg_min_move;
  logic                  cfg_enabled;
  logic [CoordBits-1:0]  trk_x, trk_y;
  logic [1:0]            trk_wheel;
  logic [NumButtons-1:0] trk_held, trk_prev_held;
  logic [TimeBits-1:0]   trk_release [NumButtons];
  logic [TimeBits-1:0]   trk_last_act;
  logic                  trk_active;

  out_item_t           expected_reports [$];
  logic [TimeBits-1:0] tick_now = '0;
  int                  src_idle_pct = 0;
  int                  sink_idle_pct = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  events_sent = 0;

  pointer_click_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic reset_tracker();
    cfg_max_x     = MaxXReset;
    cfg_max_y     = MaxYReset;
    cfg_dc_window = DcWinReset;
    cfg_min_move  = MinMoveReset;
    cfg_timeout   = TimeoutReset;
    cfg_enabled   = 1'b1;
    trk_x         = MaxXReset >> 1;
    trk_y         = MaxYReset >> 1;
    trk_wheel     = WheelNone;
    trk_held      = '0;
    trk_prev_held = '0;
    for (int i = 0; i < NumButtons; i++) trk_release[i] = '0;
    trk_last_act  = '0;
    trk_active    = 1'b1;
  endtask

  task automatic apply_cfg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    case (idx)
      RegMaxX: begin
        cfg_max_x = val[CoordBits-1:0];
        trk_x     = cfg_max_x >> 1;
      end
      RegMaxY: begin
        cfg_max_y = val[CoordBits-1:0];
        trk_y     = cfg_max_y >> 1;
      end
      RegDcWindow: cfg_dc_window = val;
      RegMinMove:  cfg_min_move = val[7:0];
      RegTimeout:  cfg_timeout = val;
      RegEnable:   cfg_enabled = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [CoordBits-1:0] clamp_coord(input int v,
                                                       input logic [CoordBits-1:0] hi);
    if (v < 0) return '0;
    if (v > int'(hi)) return hi;
    return CoordBits'(v);
  endfunction

  function automatic out_item_t predict_report(input in_item_t ev);
    int                    rx, ry, dx, dy;
    longint                sq, thr;
    logic [TimeBits-1:0]   now, gap;
    logic [NumButtons-1:0] clicks, dbl, holds;
    out_item_t             r;
    rx     = ev.pos_x;
    ry     = ev.pos_y;
    now    = ev.timestamp;
    dx     = rx - int'(trk_x);
    dy     = ry - int'(trk_y);
    clicks = '0;
    dbl    = '0;
    holds  = '0;
    trk_x  = clamp_coord(rx, cfg_max_x);
    trk_y  = clamp_coord(ry, cfg_max_y);

    // Motion and the spare command leave buttons and wheel alone.
    case (ev.cmd)
      CmdDown: begin
        if (ev.button_code < NumButtons) trk_held[ev.button_code] = 1'b1;
        else if (ev.button_code == BtnWheelUp) trk_wheel = WheelUp;
        else if (ev.button_code == BtnWheelDown) trk_wheel = WheelDown;
      end
      CmdUp: begin
        if (ev.button_code < NumButtons) trk_held[ev.button_code] = 1'b0;
        else if (ev.button_code == BtnWheelUp || ev.button_code == BtnWheelDown)
          trk_wheel = WheelNone;
      end
      default: ;
    endcase

    sq  = longint'(dx) * dx + longint'(dy) * dy;
    thr = longint'(cfg_min_move) * cfg_min_move;
    if (sq >= thr || trk_wheel != WheelNone) begin
      trk_last_act = now;
      trk_active   = 1'b1;
    end

    for (int i = 0; i < NumButtons; i++) begin
      if (trk_held[i]) begin
        trk_last_act = now;
        trk_active   = 1'b1;
        if (trk_prev_held[i]) begin
          holds[i] = 1'b1;
        end else begin
          gap = now - trk_release[i];
          if (gap < cfg_dc_window) dbl[i] = 1'b1;
        end
      end else if (trk_prev_held[i]) begin
        clicks[i]      = 1'b1;
        trk_release[i] = now;
      end
    end
    trk_prev_held = trk_held;

    gap = now - trk_last_act;
    if (trk_active && gap > cfg_timeout) trk_active = 1'b0;

    r.cur_x             = trk_x;
    r.cur_y             = trk_y;
    r.delta_x           = DeltaBits'(dx);
    r.delta_y           = DeltaBits'(dy);
    r.wheel             = trk_wheel;
    r.held_mask         = trk_held;
    r.click_mask        = clicks;
    r.double_click_mask = dbl;
    r.hold_mask         = holds;
    r.is_active         = trk_active & cfg_enabled;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cur_x             = m_axis_tdata[11:0];
      got.cur_y             = m_axis_tdata[23:12];
      got.delta_x           = m_axis_tdata[37:24];
      got.delta_y           = m_axis_tdata[51:38];
      got.wheel             = m_axis_tdata[53:52];
      got.held_mask         = m_axis_tdata[58:54];
      got.click_mask        = m_axis_tdata[63:59];
      got.double_click_mask = m_axis_tdata[68:64];
      got.hold_mask         = m_axis_tdata[73:69];
      got.is_active         = m_axis_tdata[74];
      if (expected_reports.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("cur_x", want.cur_x, got.cur_x);
        compare_field("cur_y", want.cur_y, got.cur_y);
        compare_field("delta_x", want.delta_x, got.delta_x);
        compare_field("delta_y", want.delta_y, got.delta_y);
        compare_field("wheel", want.wheel, got.wheel);
        compare_field("held_mask", want.held_mask, got.held_mask);
        compare_field("click_mask", want.click_mask, got.click_mask);
        compare_field("double_click_mask", want.double_click_mask, got.double_click_mask);
        compare_field("hold_mask", want.hold_mask, got.hold_mask);
        compare_field("is_active", want.is_active, got.is_active);
        compare_field("pad", 0, m_axis_tdata[79:75]);
      end
    end
  end

  task automatic send_event(input in_item_t ev);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.cmd;
    s_axis_tdata  <= {3'b000, ev.timestamp, ev.button_code, ev.pos_y, ev.pos_x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_reports.push_back(predict_report(ev));
    events_sent++;
  endtask

  task automatic send_at(input logic [1:0] cmd, input int x, input int y,
                         input logic [2:0] code, input int unsigned dt);
    in_item_t ev;
    tick_now       = tick_now + dt;
    ev.cmd         = cmd;
    ev.pos_x       = PosBits'(x);
    ev.pos_y       = PosBits'(y);
    ev.button_code = code;
    ev.timestamp   = tick_now;
    send_event(ev);
  endtask

  task automatic wait_reports_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_cfg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgDataBits-1:0] pick_cfg_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CfgDataBits'($urandom());
    endcase
  endfunction

  task automatic randomize_config();
    cfg_write(RegMaxX, pick_cfg_value());
    cfg_write(RegMaxY, pick_cfg_value());
    cfg_write(RegDcWindow, pick_cfg_value());
    cfg_write(RegMinMove, pick_cfg_value());
    cfg_write(RegTimeout, pick_cfg_value());
    cfg_write(RegEnable, pick_cfg_value());
  endtask

  // Moves are sized around the activity radius so both sides of it are hit.
  task automatic send_motion(input int unsigned dt);
    int span, x, y;
    span = ($urandom_range(2) == 0) ? 20 : int'(cfg_min_move) + 3;
    x    = int'(trk_x) + int'($urandom_range(2 * span)) - span;
    y    = int'(trk_y) + int'($urandom_range(2 * span)) - span;
    send_at(CmdMotion, x, y, BtnNone, dt);
  endtask

  task automatic send_button(input logic [1:0] cmd, input int code, input int unsigned dt);
    send_at(cmd, trk_x, trk_y, 3'(code), dt);
  endtask

  task automatic send_random_sequence();
    int  kind, b, c, w, dt;
    bit  chord;
    kind  = $urandom_range(99);
    b     = $urandom_range(NumButtons - 1);
    c     = (b + 1 + $urandom_range(NumButtons - 2)) % NumButtons;
    chord = $urandom_range(1);
    if (kind < 40) begin
      send_motion($urandom_range(1, 60));
    end else if (kind < 62) begin
      send_button(CmdDown, b, $urandom_range(1, 300));
      if (chord) send_button(CmdDown, c, $urandom_range(1, 50));
      repeat ($urandom_range(2)) send_motion($urandom_range(1, 100));
      send_button(CmdUp, b, $urandom_range(1, 200));
      if (chord) send_button(CmdUp, c, $urandom_range(1, 50));
    end else if (kind < 74) begin
      // Second press lands a short gap later, or just inside, on or just past the double-click window.
      w = int'(cfg_dc_window);
      send_button(CmdDown, b, $urandom_range(1, 100));
      send_button(CmdUp, b, $urandom_range(1, 100));
      dt = chord ? w + int'($urandom_range(2)) - 1 : int'($urandom_range(1, 50));
      send_button(CmdDown, b, (dt < 0) ? 0 : dt);
      send_button(CmdUp, b, $urandom_range(1, 100));
    end else if (kind < 82) begin
      send_button(CmdDown, chord ? BtnWheelUp : BtnWheelDown, $urandom_range(1, 100));
      if ($urandom_range(1)) send_motion($urandom_range(1, 100));
      send_button(CmdUp, $urandom_range(1) ? BtnWheelUp : BtnWheelDown,
                  $urandom_range(1, 100));
    end else if (kind < 90) begin
      // Quiet spell around the activity timeout.
      dt = int'(cfg_timeout) + int'($urandom_range(4)) - 2;
      send_button(CmdMotion, BtnNone, (dt < 0) ? 0 : dt);
    end else begin
      if ($urandom_range(1)) tick_now = $urandom();
      send_at(2'($urandom_range(3)), int'($urandom_range(8191)) - 4096,
              int'($urandom_range(8191)) - 4096, 3'($urandom_range(7)),
              $urandom_range(1) ? 0 : $urandom_range(1, 1000));
    end
  endtask

  task automatic test_default_behavior();
    send_at(CmdMotion, 360, 288, BtnNone, 10);
    send_at(CmdMotion, -4096, -4096, 3'd0, 10);
    send_at(CmdMotion, 4095, 4095, BtnNone, 10);
    send_at(CmdSpare, 100, 100, 3'd1, 10);
    // Release times start at zero, so an early first press is a double click.
    send_at(CmdDown, 100, 100, 3'd0, 60);
    send_at(CmdMotion, 101, 100, BtnNone, 50);
    send_at(CmdUp, 101, 100, 3'd0, 50);
    send_at(CmdDown, 101, 100, 3'd0, 100);
    send_at(CmdUp, 101, 100, 3'd0, 10);
    send_at(CmdDown, 101, 100, 3'd1, 1700);
    send_at(CmdDown, 101, 100, 3'd2, 1);
    send_at(CmdDown, 101, 100, 3'd3, 1);
    send_at(CmdDown, 101, 100, 3'd4, 1);
    send_at(CmdUp, 101, 100, 3'd4, 1);
    send_at(CmdUp, 101, 100, 3'd3, 1);
    send_at(CmdUp, 101, 100, 3'd2, 1);
    send_at(CmdUp, 101, 100, 3'd1, 1);
    send_at(CmdDown, 101, 100, BtnNone, 1);
    send_at(CmdUp, 101, 100, BtnNone, 1);
    send_at(CmdDown, 101, 100, BtnWheelUp, 1);
    send_at(CmdUp, 101, 100, BtnWheelUp, 1);
    send_at(CmdDown, 101, 100, BtnWheelDown, 1);
    send_at(CmdUp, 101, 100, BtnWheelDown, 1);
    send_at(CmdMotion, 101, 100, BtnNone, 6000);
    // Hold a button across the wrap of the time counter, then release and press again.
    tick_now = 32'hFFFF_FFF0;
    send_at(CmdDown, 101, 100, 3'd0, 0);
    send_at(CmdUp, 101, 100, 3'd0, 32'h20);
    send_at(CmdDown, 101, 100, 3'd0, 10);
    send_at(CmdUp, 101, 100, 3'd0, 1);
    wait_reports_drained();
  endtask

  task automatic test_config_extremes();
    cfg_write(RegMaxX, '0);
    cfg_write(RegMaxY, 16'h0FFF);
    cfg_write(RegDcWindow, '0);
    cfg_write(RegMinMove, 16'h00FF);
    cfg_write(RegTimeout, '0);
    cfg_write(RegEnable, '0);
    cfg_write(RegUnused, '1);
    send_at(CmdMotion, 4095, 4095, BtnNone, 1);
    send_at(CmdDown, 10, 10, 3'd2, 0);
    send_at(CmdUp, 10, 10, 3'd2, 1);
    wait_reports_drained();
    cfg_write(RegMaxX, 16'h0FFF);
    cfg_write(RegMaxY, '0);
    cfg_write(RegDcWindow, '1);
    cfg_write(RegMinMove, '0);
    cfg_write(RegTimeout, '1);
    cfg_write(RegEnable, 16'h0001);
    send_at(CmdMotion, 4095, -1, BtnNone, 1);
    send_at(CmdDown, 4095, 0, 3'd2, 65534);
    send_at(CmdUp, 0, 0, 3'd2, 1);
    wait_reports_drained();
  endtask

  task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
    int stop_at;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = events_sent + n_items;
    while (events_sent < stop_at) begin
      wait_reports_drained();
      randomize_config();
      repeat ($urandom_range(40, 80)) send_random_sequence();
    end
    wait_reports_drained();
  endtask

  // Bursts with the sender held back until every result is out.
  task automatic test_drain_pause();
    src_idle_pct  = 0;
    sink_idle_pct = 30;
    repeat (4) begin
      repeat (6) send_motion($urandom_range(1, 40));
      wait_reports_drained();
    end
  endtask

  initial begin
    reset_tracker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_behavior();
    test_config_extremes();
    test_drain_pause();
    test_random_traffic(360, 8, 50);
    test_random_traffic(360, 50, 8);
    test_random_traffic(360, 0, 0);

    wait_reports_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
